// ===== src/pwgt_pkg.sv =====
// Shared constants and controller/datapath interface types for the page write gap tracker.
package pwgt_pkg;

    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_COUNT    = 1048576;
    localparam int MAX_REQ_PAGES = 64;

    localparam int OFFSET_W   = 32;
    localparam int SIZE_W     = 19;
    localparam int DATA_W     = 56;
    localparam int PAGE_IDX_W = 20;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_AW    = $clog2(PAGE_COUNT);
    localparam int FP_W       = OFFSET_W - PAGE_SHIFT;
    localparam int AV_W       = OFFSET_W + 1;
    localparam int CNT_W      = $clog2(MAX_REQ_PAGES + 1);
    localparam int ENTRY_W    = DATA_W + 1;

    localparam logic [DATA_W-1:0] LIMIT_RESET = 56'd16106127360000;
    localparam logic [DATA_W-1:0] COUNT_MAX   = {DATA_W{1'b1}};

    typedef struct packed {
        logic clr;     // write a zero entry at the clear address, advance it
        logic accept;  // input beat taken this cycle
        logic upd;     // update current page, load result, step to next page
    } t_cmd;

    typedef struct packed {
        logic clr_done;   // clear address is at the last entry
        logic go;         // offered beat is a write below the limit with pages to handle
        logic last_page;  // current page is the final one of the run
        logic slot_free;  // result register empty or being taken
    } t_status;

endpackage

// ===== src/pwgt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pwgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pwgt_ctrl.sv =====
// Controller state machine: clearing pass, beat intake and per-page sequencing.
module pwgt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pwgt_pkg::t_status i_status,
    output pwgt_pkg::t_cmd   o_cmd,
    output logic             o_in_ready
);
    import pwgt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept = i_in_valid && r_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_status.go) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // read data lands in the RAM output register
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_status.slot_free) begin
                    n_state = i_status.last_page ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.clr    = (r_state == S_CLEAR);
        o_cmd.accept = accept;
        o_cmd.upd    = (r_state == S_UPD) && i_status.slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

`ifndef SYNTHESIS
    a_go_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.go) |=> (r_state == S_READ))
        else $error("qualifying write did not start a page read");

    a_read_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_UPD))
        else $error("page read not followed by update");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !i_status.slot_free) |=> (r_state == S_UPD))
        else $error("update left while result register was blocked");
`endif

endmodule

// ===== src/pwgt_dp.sv =====
// Datapath: byte counter, limit register, page table RAM and result register.
module pwgt_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pwgt_pkg::t_cmd                       i_cmd,
    output pwgt_pkg::t_status                    o_status,
    input  logic                                 i_cfg_we,
    input  logic [pwgt_pkg::DATA_W-1:0]          i_cfg_wdata,
    input  logic                                 i_is_write,
    input  logic [pwgt_pkg::OFFSET_W-1:0]        i_offset_bytes,
    input  logic [pwgt_pkg::SIZE_W-1:0]          i_size_bytes,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [pwgt_pkg::PAGE_IDX_W-1:0]      o_page_index,
    output logic                                 o_had_previous,
    output logic [pwgt_pkg::DATA_W-1:0]          o_gap_bytes,
    output logic                                 o_last_of_run
);
    import pwgt_pkg::*;

    logic [DATA_W-1:0]   r_limit;
    logic [DATA_W-1:0]   r_bytes;
    logic [DATA_W-1:0]   r_pos;
    logic [PAGE_AW-1:0]  r_page;
    logic [CNT_W-1:0]    r_left;
    logic [PAGE_AW-1:0]  r_clr_addr;

    logic                  r_out_valid;
    logic [PAGE_IDX_W-1:0] r_page_index;
    logic                  r_had_prev;
    logic [DATA_W-1:0]     r_gap;
    logic                  r_last;

    logic [FP_W-1:0]     start_pg;
    logic [SIZE_W:0]     size_up;
    logic [SIZE_W:0]     npages_raw;
    logic [CNT_W-1:0]    npages;
    logic [AV_W-1:0]     avail;
    logic [CNT_W-1:0]    n_eff;
    logic                qualify;
    logic [DATA_W:0]     sum;
    logic [DATA_W-1:0]   n_bytes;

    logic                ram_we;
    logic [PAGE_AW-1:0]  ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                hit;

    // pages spanned, rounded up and capped
    assign start_pg   = i_offset_bytes[OFFSET_W-1:PAGE_SHIFT];
    assign size_up    = {1'b0, i_size_bytes} + (SIZE_W+1)'(PAGE_BYTES - 1);
    assign npages_raw = size_up >> PAGE_SHIFT;
    assign npages     = (npages_raw > (SIZE_W+1)'(MAX_REQ_PAGES))
                        ? CNT_W'(MAX_REQ_PAGES) : CNT_W'(npages_raw);

    // drop pages past the end of the table
    assign avail = (AV_W'(start_pg) >= AV_W'(PAGE_COUNT))
                   ? '0 : (AV_W'(PAGE_COUNT) - AV_W'(start_pg));
    assign n_eff = (avail < AV_W'(npages)) ? CNT_W'(avail) : npages;

    assign qualify = i_is_write && (r_bytes < r_limit);
    assign sum     = {1'b0, r_bytes} + (DATA_W+1)'(i_size_bytes);
    assign n_bytes = sum[DATA_W] ? COUNT_MAX : sum[DATA_W-1:0];

    assign o_status.clr_done  = (r_clr_addr == PAGE_AW'(PAGE_COUNT - 1));
    assign o_status.go        = qualify && (n_eff != '0);
    assign o_status.last_page = (r_left == CNT_W'(1));
    assign o_status.slot_free = !r_out_valid || i_out_ready;

    // entry layout: seen mark above the byte count of the last write
    assign ram_we    = i_cmd.clr || i_cmd.upd;
    assign ram_waddr = i_cmd.clr ? r_clr_addr : r_page;
    assign ram_wdata = i_cmd.clr ? '0 : {1'b1, r_pos};
    assign hit       = ram_rdata[DATA_W];

    pwgt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_page),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_bytes     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.accept && qualify) begin
                r_bytes <= n_bytes;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + PAGE_AW'(1);
            end
            if (i_cmd.upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && qualify) begin
            r_pos  <= r_bytes;
            r_page <= PAGE_AW'(start_pg);
            r_left <= n_eff;
        end else if (i_cmd.upd) begin
            r_page <= r_page + PAGE_AW'(1);
            r_left <= r_left - CNT_W'(1);
        end
        if (i_cmd.upd) begin
            r_page_index <= PAGE_IDX_W'(r_page);
            r_had_prev   <= hit;
            r_gap        <= hit ? (r_pos - ram_rdata[DATA_W-1:0]) : '0;
            r_last       <= (r_left == CNT_W'(1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_index   = r_page_index;
    assign o_had_previous = r_had_prev;
    assign o_gap_bytes    = r_gap;
    assign o_last_of_run  = r_last;

endmodule

// ===== src/page_write_gap_tracker.sv =====
// Top level of the page write gap tracker: controller and datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_is_write, i_offset_bytes, i_size_bytes
//  result   | o_out_valid / i_out_ready  | o_page_index, o_had_previous, o_gap_bytes,
//           |                            | o_last_of_run
//  config   | i_cfg_we                   | i_cfg_wdata (write limit)
//
// An access beat is taken in the idle state; each page it updates then takes a read of
// the page table RAM, then a write back that also loads the result register.
// After reset all 1,048,576 page table entries are swept clear, one entry a cycle;
// o_in_ready stays low meanwhile, configuration writes are taken.
// A held result stalls the page update until the result beat is taken.
module page_write_gap_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pwgt_pkg::DATA_W-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_is_write,
    input  logic [pwgt_pkg::OFFSET_W-1:0]        i_offset_bytes,
    input  logic [pwgt_pkg::SIZE_W-1:0]          i_size_bytes,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [pwgt_pkg::PAGE_IDX_W-1:0]      o_page_index,
    output logic                                 o_had_previous,
    output logic [pwgt_pkg::DATA_W-1:0]          o_gap_bytes,
    output logic                                 o_last_of_run
);
    import pwgt_pkg::*;

    t_cmd    cmd;
    t_status status;

    pwgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    pwgt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_is_write     (i_is_write),
        .i_offset_bytes (i_offset_bytes),
        .i_size_bytes   (i_size_bytes),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_page_index   (o_page_index),
        .o_had_previous (o_had_previous),
        .o_gap_bytes    (o_gap_bytes),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for page_write_gap_tracker: scoreboard, random traffic, limits.
`timescale 1ns / 1ps

module tb;
    import pwgt_pkg::*;

    localparam int DRAIN_CYCLES   = 2 * MAX_REQ_PAGES + 16;
    localparam int TIMEOUT_CYCLES = 3 * PAGE_COUNT + 400 * MAX_REQ_PAGES * 16;
    localparam int MAX_REPORTS    = 50;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_BURSTY} t_ready_mode;

    typedef struct {
        bit [PAGE_IDX_W-1:0] page;
        bit                  had_prev;
        bit [DATA_W-1:0]     gap;
        bit                  last;
    } t_page_result;

    class t_gap_scoreboard;
        bit [DATA_W-1:0] limit;
        bit [DATA_W-1:0] bytes_written;
        bit [DATA_W-1:0] last_pos [int unsigned];  // an entry exists once the page is written
        t_page_result    expected_q [$];
        int              errors;
        int              beats_taken;
        int              writes_tracked;
        int              results_checked;

        function new();
            limit           = LIMIT_RESET;
            bytes_written   = '0;
            errors          = 0;
            beats_taken     = 0;
            writes_tracked  = 0;
            results_checked = 0;
        endfunction

        // Return 1 when the beat is a write that moves the tracker state.
        function bit note_access(bit is_wr, bit [OFFSET_W-1:0] off, bit [SIZE_W-1:0] size);
            int unsigned  start_pg;
            int unsigned  npages;
            int unsigned  pg;
            int unsigned  last_pg;
            t_page_result r;
            bit [DATA_W:0] sum;
            beats_taken++;
            if (!is_wr || bytes_written >= limit)
                return 1'b0;
            writes_tracked++;
            start_pg = off >> PAGE_SHIFT;
            npages   = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
            if (npages > MAX_REQ_PAGES)
                npages = MAX_REQ_PAGES;
            last_pg = start_pg + npages - 1;
            if (last_pg >= PAGE_COUNT)
                last_pg = PAGE_COUNT - 1;
            for (int i = 0; i < npages; i++) begin
                pg = start_pg + i;
                if (pg >= PAGE_COUNT)
                    continue;
                r.page     = pg[PAGE_IDX_W-1:0];
                r.had_prev = last_pos.exists(pg);
                r.gap      = '0;
                if (r.had_prev)
                    r.gap = bytes_written - last_pos[pg];
                r.last      = (pg == last_pg);
                last_pos[pg] = bytes_written;
                expected_q.insert(expected_q.size(), r);
            end
            sum = {1'b0, bytes_written} + size;
            if (sum > COUNT_MAX)
                sum = {1'b0, COUNT_MAX};
            bytes_written = sum[DATA_W-1:0];
            return 1'b1;
        endfunction

        function void report(string field, bit [DATA_W-1:0] exp_v, bit [DATA_W-1:0] act_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, field, exp_v, act_v);
        endfunction

        function void check_result(bit [PAGE_IDX_W-1:0] page, bit had_prev,
                                   bit [DATA_W-1:0] gap, bit last);
            t_page_result exp_r;
            results_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result for page 0x%0h with none expected, actual gap 0x%0h",
                             $time, page, gap);
                return;
            end
            exp_r = expected_q.pop_front();
            if (page != exp_r.page)
                report("page_index", exp_r.page, page);
            if (had_prev != exp_r.had_prev)
                report("had_previous", exp_r.had_prev, had_prev);
            if (gap != exp_r.gap)
                report("gap_bytes", exp_r.gap, gap);
            if (last != exp_r.last)
                report("last_of_run", exp_r.last, last);
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [DATA_W-1:0]     i_cfg_wdata    = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_is_write     = 1'b0;
    logic [OFFSET_W-1:0]   i_offset_bytes = '0;
    logic [SIZE_W-1:0]     i_size_bytes   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [PAGE_IDX_W-1:0] o_page_index;
    logic                  o_had_previous;
    logic [DATA_W-1:0]     o_gap_bytes;
    logic                  o_last_of_run;

    t_gap_scoreboard sb = new();
    t_ready_mode   ready_mode = READY_RANDOM;
    int            ready_phase = 0;
    int            ready_run   = 0;
    bit            ready_hold  = 1'b0;
    int            cycles      = 0;

    page_write_gap_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_is_write     (i_is_write),
        .i_offset_bytes (i_offset_bytes),
        .i_size_bytes   (i_size_bytes),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_page_index   (o_page_index),
        .o_had_previous (o_had_previous),
        .o_gap_bytes    (o_gap_bytes),
        .o_last_of_run  (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, sb.expected_q.size());
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_page_index, o_had_previous, o_gap_bytes, o_last_of_run);
    end

    // Result-side back-pressure.
    always @(negedge i_clk) begin
        case (ready_mode)
            READY_ALWAYS: i_out_ready = 1'b1;
            READY_RANDOM: i_out_ready = ($urandom_range(0, 3) != 0);
            READY_PERIODIC: begin
                i_out_ready = (ready_phase < 2);
                ready_phase = (ready_phase + 1) % 5;
            end
            default: begin
                if (ready_run == 0) begin
                    ready_hold = ~ready_hold;
                    ready_run  = ready_hold ? $urandom_range(1, 10) : $urandom_range(1, 6);
                end
                ready_run--;
                i_out_ready = ready_hold;
            end
        endcase
    end

    // Entered at a falling edge; leaves at a falling edge with valid still high.
    task automatic send_beat(input bit is_wr, input bit [OFFSET_W-1:0] off,
                             input bit [SIZE_W-1:0] size, output bit took);
        i_in_valid     = 1'b1;
        i_is_write     = is_wr;
        i_offset_bytes = off;
        i_size_bytes   = size;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        took = sb.note_access(is_wr, off, size);
        @(negedge i_clk);
    endtask

    task automatic send(input bit is_wr, input bit [OFFSET_W-1:0] off,
                        input bit [SIZE_W-1:0] size);
        bit took;
        send_beat(is_wr, off, size, took);
    endtask

    // Hold off until every expected page result is back and the block has gone quiet.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_limit(input bit [DATA_W-1:0] value);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.limit = value;
    endtask

    task automatic send_random_beat(output bit took);
        bit                  is_wr;
        bit [OFFSET_W-1:0]   off;
        bit [SIZE_W-1:0]     size;
        int                  pick;
        is_wr = ($urandom_range(0, 99) >= 15);
        pick  = $urandom_range(0, 99);
        // Mostly a small page pool so gaps show up; some full-range and table-end offsets.
        if (pick < 70)
            off = {20'($urandom_range(0, 47)), 12'($urandom_range(0, PAGE_BYTES - 1))};
        else if (pick < 85)
            off = $urandom;
        else
            off = {20'($urandom_range(PAGE_COUNT - 64, PAGE_COUNT - 1)),
                   12'($urandom_range(0, PAGE_BYTES - 1))};
        pick = $urandom_range(0, 99);
        if (pick < 5)
            size = '0;
        else if (pick < 55)
            size = SIZE_W'($urandom_range(1, 4 * PAGE_BYTES));
        else if (pick < 80)
            size = SIZE_W'($urandom_range(1, 16 * PAGE_BYTES));
        else if (pick < 93)
            size = SIZE_W'($urandom_range(1, MAX_REQ_PAGES * PAGE_BYTES));
        else
            size = SIZE_W'($urandom_range(MAX_REQ_PAGES * PAGE_BYTES + 1, (1 << SIZE_W) - 1));
        send_beat(is_wr, off, size, took);
    endtask

    task automatic run_random(input int target, input bit idle_on);
        int taken;
        int sent;
        int burst;
        int gap;
        bit took;
        taken = 0;
        sent  = 0;
        while (taken < target && sent < target + target / 4) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                send_random_beat(took);
                sent++;
                if (took)
                    taken++;
            end
            gap = idle_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats under the reset limit; the first one waits out the table sweep.
        ready_mode = READY_RANDOM;
        send(1'b0, 32'h0000_1000, 19'd4096);
        send(1'b1, 32'h0000_0000, 19'd0);
        send(1'b1, 32'h0000_0000, 19'd1);
        send(1'b1, 32'h0000_0000, 19'd4096);
        send(1'b1, 32'h0000_0FFF, 19'd4097);
        send(1'b1, 32'hFFFF_FFFF, 19'd4096);
        send(1'b1, 32'hFFFF_F000, 19'd262144);
        send(1'b1, 32'hFFFC_0000, 19'h7FFFF);
        send(1'b1, 32'h0000_0000, 19'd262144);
        send(1'b1, 32'h0001_2345, 19'd1);
        send(1'b0, 32'hFFFF_FFFF, 19'h7FFFF);
        send(1'b1, 32'h8000_0000, 19'h40000);
        send(1'b1, 32'h7FFF_FFFF, 19'h3FFFF);

        // Limits: zero blocks all, one byte above lets one write in, exact blocks, raise resumes.
        set_limit('0);
        send(1'b1, 32'h0000_0000, 19'd4096);
        send(1'b1, 32'h0000_3000, 19'd8192);
        set_limit(sb.bytes_written + 1);
        send(1'b1, 32'h0000_3000, 19'd8192);
        send(1'b1, 32'h0000_3000, 19'd100);
        set_limit(sb.bytes_written);
        send(1'b1, 32'h0000_4000, 19'd4096);
        set_limit(COUNT_MAX);
        send(1'b1, 32'h0000_3000, 19'd8192);

        ready_mode = READY_RANDOM;
        run_random(30, 1'b1);

        set_limit(LIMIT_RESET);
        ready_mode = READY_PERIODIC;
        run_random(30, 1'b0);

        // Limit lands partway through this phase.
        set_limit(sb.bytes_written + $urandom_range(200000, 800000));
        ready_mode = READY_BURSTY;
        run_random(30, 1'b1);

        set_limit(COUNT_MAX);
        ready_mode = READY_ALWAYS;
        run_random(30, 1'b1);

        wait_drained();
        $display("covered %0d access beats, %0d tracked writes, %0d page results checked",
                 sb.beats_taken, sb.writes_tracked, sb.results_checked);
        $display("limits: reset, zero, exact, mid-run and all-ones; %0d pages touched",
                 sb.last_pos.num());
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("tb failed");
        end
        $finish;
    end

endmodule
